[src/swd_pkg.sv]
`default_nettype none

package swd_pkg;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TURN1,
        PH_ACK,
        PH_TURN2,
        PH_DATA,
        PH_PARITY
    } phase_t;

    localparam logic [1:0] KIND_OK    = 2'd0;
    localparam logic [1:0] KIND_WAIT  = 2'd1;
    localparam logic [1:0] KIND_FAULT = 2'd2;
    localparam logic [1:0] KIND_RESET = 2'd3;

    localparam logic [2:0] ACK_CODE_OK    = 3'd1;
    localparam logic [2:0] ACK_CODE_WAIT  = 3'd2;
    localparam logic [2:0] ACK_CODE_FAULT = 3'd4;

    localparam logic [7:0] REQ_FRAME_MASK  = 8'hC1;
    localparam logic [7:0] REQ_FRAME_MATCH = 8'h81;

    localparam logic [7:0] RESET_MIN_DEFAULT = 8'd50;
    localparam int         DATA_BITS         = 32;
    localparam logic [5:0] DATA_LAST         = 6'(DATA_BITS - 1);
    localparam logic [5:0] ACK_LAST          = 6'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [4:0] REG_DP_IDCODE   = 5'd0;
    localparam logic [4:0] REG_DP_ABORT    = 5'd1;
    localparam logic [4:0] REG_DP_WCR      = 5'd2;
    localparam logic [4:0] REG_DP_CTRLSTAT = 5'd3;
    localparam logic [4:0] REG_DP_RESEND   = 5'd4;
    localparam logic [4:0] REG_DP_SELECT   = 5'd5;
    localparam logic [4:0] REG_DP_RDBUFF   = 5'd6;
    localparam logic [4:0] REG_DP_ROUTESEL = 5'd7;
    localparam logic [4:0] REG_AP_CSW      = 5'd8;
    localparam logic [4:0] REG_AP_TAR      = 5'd9;
    localparam logic [4:0] REG_AP_DRW      = 5'd10;
    localparam logic [4:0] REG_AP_BD0      = 5'd11;
    localparam logic [4:0] REG_AP_BD1      = 5'd12;
    localparam logic [4:0] REG_AP_BD2      = 5'd13;
    localparam logic [4:0] REG_AP_BD3      = 5'd14;
    localparam logic [4:0] REG_AP_CFG      = 5'd15;
    localparam logic [4:0] REG_AP_BASE     = 5'd16;
    localparam logic [4:0] REG_AP_IDR      = 5'd17;
    localparam logic [4:0] REG_AP_RAZ      = 5'd18;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  request;
        logic [2:0]  ack;
        logic [31:0] data;
        logic [15:0] ones;
    } rec_t;

    function automatic logic request_ok(input logic [7:0] w);
        logic frame_ok;
        logic par_ok;
        frame_ok = (w & REQ_FRAME_MASK) == REQ_FRAME_MATCH;
        par_ok   = (w[1] ^ w[2] ^ w[3] ^ w[4]) == w[5];
        return frame_ok && par_ok;
    endfunction

    function automatic logic [4:0] decode_register(input logic [7:0] req,
                                                   input logic [31:0] sel);
        logic [3:0] addr;
        logic       rd;
        logic [7:0] ap;
        logic [4:0] id;
        addr = {req[4:3], 2'b00};
        rd   = req[2];
        ap   = {sel[7:4], addr};
        if (req[1])
        begin
            case (ap)
                8'h00:   id = REG_AP_CSW;
                8'h04:   id = REG_AP_TAR;
                8'h0C:   id = REG_AP_DRW;
                8'h10:   id = REG_AP_BD0;
                8'h14:   id = REG_AP_BD1;
                8'h18:   id = REG_AP_BD2;
                8'h1C:   id = REG_AP_BD3;
                8'hF4:   id = REG_AP_CFG;
                8'hF8:   id = REG_AP_BASE;
                8'hFC:   id = REG_AP_IDR;
                default: id = REG_AP_RAZ;
            endcase
        end
        else
        begin
            case (req[4:3])
                2'd0:    id = rd ? REG_DP_IDCODE : REG_DP_ABORT;
                2'd1:    id = sel[0] ? REG_DP_WCR : REG_DP_CTRLSTAT;
                2'd2:    id = rd ? REG_DP_RESEND : REG_DP_SELECT;
                default: id = rd ? REG_DP_RDBUFF : REG_DP_ROUTESEL;
            endcase
        end
        return id;
    endfunction

endpackage

`default_nettype wire

[src/swd_ifs.sv]
`default_nettype none

interface swd_bit_if;
    logic valid;
    logic ready;
    logic swdio_bit;

    modport source (output valid, output swdio_bit, input ready);
    modport sink (input valid, input swdio_bit, output ready);
endinterface

interface swd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] reset_min_ones;

    modport source (output valid, output reset_min_ones, input ready);
    modport sink (input valid, input reset_min_ones, output ready);
endinterface

interface swd_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic [7:0]  request_value;
    logic        access_port;
    logic        is_read;
    logic [3:0]  reg_address;
    logic [4:0]  register_id;
    logic [2:0]  ack_code;
    logic [31:0] data_word;
    logic [15:0] reset_ones;

    modport source (output valid, output record_kind, output request_value,
                    output access_port, output is_read, output reg_address,
                    output register_id, output ack_code, output data_word,
                    output reset_ones, input ready);
    modport sink (input valid, input record_kind, input request_value,
                  input access_port, input is_read, input reg_address,
                  input register_id, input ack_code, input data_word,
                  input reset_ones, output ready);
endinterface

`default_nettype wire

[src/swd_front.sv]
`default_nettype none

module swd_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    swd_bit_if.sink          sample,
    swd_cfg_if.sink          cfg,
    input  wire logic        queue_full,
    output swd_pkg::rec_t    push_rec,
    output logic             push_valid
);

    swd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  min_ones_reg;
    logic [7:0]  window_reg, window_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [7:0]  req_reg, req_next;
    logic [2:0]  ack_reg, ack_next;
    logic [31:0] shift_reg, shift_next;
    logic        parity_reg, parity_next;
    logic [15:0] ones_reg, ones_next;

    logic        accept;
    logic        b;
    logic [7:0]  win_shift;
    logic        req_hit;
    logic [2:0]  ack_new;
    logic [7:0]  min_eff;
    logic        run_done;
    logic [15:0] ones_inc;

    assign sample.ready = !queue_full;
    assign cfg.ready    = 1'b1;
    assign accept       = sample.valid && sample.ready;
    assign b            = sample.swdio_bit;
    assign win_shift    = {b, window_reg[7:1]};
    assign req_hit      = swd_pkg::request_ok(win_shift);
    assign ack_new      = ack_reg | 3'({2'b00, b} << cnt_reg[1:0]);
    assign min_eff      = (min_ones_reg == 8'd0) ? 8'd1 : min_ones_reg;
    assign run_done     = !b && (ones_reg >= {8'd0, min_eff});
    assign ones_inc     = (ones_reg == 16'hFFFF) ? ones_reg : ones_reg + 16'd1;

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_reg)
                swd_pkg::PH_TURN1:
                    phase_next = swd_pkg::PH_ACK;
                swd_pkg::PH_ACK:
                    if (cnt_reg == swd_pkg::ACK_LAST)
                    begin
                        if (ack_new != swd_pkg::ACK_CODE_OK)
                            phase_next = swd_pkg::PH_HUNT;
                        else if (req_reg[2])
                            phase_next = swd_pkg::PH_DATA;
                        else
                            phase_next = swd_pkg::PH_TURN2;
                    end
                swd_pkg::PH_TURN2:
                    phase_next = swd_pkg::PH_DATA;
                swd_pkg::PH_DATA:
                    if (cnt_reg == swd_pkg::DATA_LAST)
                        phase_next = swd_pkg::PH_PARITY;
                swd_pkg::PH_PARITY:
                    phase_next = swd_pkg::PH_HUNT;
                default:
                    phase_next = (!run_done && req_hit) ? swd_pkg::PH_TURN1
                                                        : swd_pkg::PH_HUNT;
            endcase
        end
    end

    always_comb
    begin
        window_next = window_reg;
        cnt_next    = cnt_reg;
        req_next    = req_reg;
        ack_next    = ack_reg;
        shift_next  = shift_reg;
        parity_next = parity_reg;
        ones_next   = ones_reg;
        push_valid  = 1'b0;
        push_rec.kind    = swd_pkg::KIND_OK;
        push_rec.request = req_reg;
        push_rec.ack     = ack_new;
        push_rec.data    = 32'd0;
        push_rec.ones    = 16'd0;
        if (accept)
        begin
            case (phase_reg)
                swd_pkg::PH_TURN1:
                begin
                    cnt_next = 6'd0;
                    ack_next = 3'd0;
                end
                swd_pkg::PH_ACK:
                begin
                    ack_next = ack_new;
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg == swd_pkg::ACK_LAST)
                    begin
                        cnt_next = 6'd0;
                        if (ack_new == swd_pkg::ACK_CODE_WAIT
                                || ack_new == swd_pkg::ACK_CODE_FAULT)
                        begin
                            push_valid    = 1'b1;
                            push_rec.kind = (ack_new == swd_pkg::ACK_CODE_WAIT)
                                          ? swd_pkg::KIND_WAIT : swd_pkg::KIND_FAULT;
                        end
                        if (ack_new != swd_pkg::ACK_CODE_OK)
                        begin
                            window_next = 8'd0;
                            ones_next   = 16'd0;
                        end
                        else
                        begin
                            shift_next  = 32'd0;
                            parity_next = 1'b0;
                        end
                    end
                end
                swd_pkg::PH_TURN2:
                    cnt_next = 6'd0;
                swd_pkg::PH_DATA:
                begin
                    shift_next  = {b, shift_reg[31:1]};
                    parity_next = parity_reg ^ b;
                    cnt_next    = (cnt_reg == swd_pkg::DATA_LAST) ? 6'd0 : cnt_reg + 6'd1;
                end
                swd_pkg::PH_PARITY:
                begin
                    if (b == parity_reg)
                    begin
                        push_valid    = 1'b1;
                        push_rec.kind = swd_pkg::KIND_OK;
                        push_rec.ack  = ack_reg;
                        push_rec.data = shift_reg;
                    end
                    window_next = 8'd0;
                    cnt_next    = 6'd0;
                    ones_next   = 16'd0;
                end
                default:
                begin
                    if (run_done)
                    begin
                        push_valid       = 1'b1;
                        push_rec.kind    = swd_pkg::KIND_RESET;
                        push_rec.request = 8'd0;
                        push_rec.ack     = 3'd0;
                        push_rec.ones    = ones_reg;
                        window_next      = 8'd0;
                        cnt_next         = 6'd0;
                        ones_next        = 16'd0;
                    end
                    else
                    begin
                        ones_next = b ? ones_inc : 16'd0;
                        if (req_hit)
                        begin
                            req_next    = win_shift;
                            window_next = 8'd0;
                            ones_next   = 16'd0;
                            cnt_next    = 6'd0;
                        end
                        else
                        begin
                            window_next = win_shift;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= swd_pkg::PH_HUNT;
            min_ones_reg <= swd_pkg::RESET_MIN_DEFAULT;
            window_reg   <= 8'd0;
            cnt_reg      <= 6'd0;
            req_reg      <= 8'd0;
            ack_reg      <= 3'd0;
            shift_reg    <= 32'd0;
            parity_reg   <= 1'b0;
            ones_reg     <= 16'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            cnt_reg    <= cnt_next;
            req_reg    <= req_next;
            ack_reg    <= ack_next;
            shift_reg  <= shift_next;
            parity_reg <= parity_next;
            ones_reg   <= ones_next;
            if (cfg.valid && cfg.ready)
                min_ones_reg <= cfg.reset_min_ones;
        end
    end

endmodule

`default_nettype wire

[src/swd_queue.sv]
`default_nettype none

module swd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    input  wire swd_pkg::rec_t push_rec,
    input  wire logic          pop,
    output logic               full,
    output logic               head_valid,
    output swd_pkg::rec_t      head_rec
);

    swd_pkg::rec_t                   mem_reg [swd_pkg::QUEUE_DEPTH];
    logic [swd_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [swd_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [swd_pkg::QUEUE_CW-1:0]    count_reg;
    logic                            do_push;
    logic                            do_pop;

    assign full       = count_reg == swd_pkg::QUEUE_CW'(swd_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_rec   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + swd_pkg::QUEUE_AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + swd_pkg::QUEUE_AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + swd_pkg::QUEUE_CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - swd_pkg::QUEUE_CW'(1);
        end
    end

endmodule

`default_nettype wire

[src/swd_back.sv]
`default_nettype none

module swd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire swd_pkg::rec_t head_rec,
    output logic               pop,
    swd_rec_if.source          result
);

    logic        valid_reg;
    logic [31:0] sel_copy_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  req_reg;
    logic [4:0]  reg_id_reg;
    logic [2:0]  ack_reg;
    logic [31:0] data_reg;
    logic [15:0] ones_reg;
    logic [4:0]  reg_id;
    logic        is_xfer;

    assign pop     = head_valid && (!valid_reg || result.ready);
    assign is_xfer = head_rec.kind != swd_pkg::KIND_RESET;
    assign reg_id  = is_xfer ? swd_pkg::decode_register(head_rec.request, sel_copy_reg)
                             : 5'd0;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg   <= head_rec.kind;
            req_reg    <= head_rec.request;
            reg_id_reg <= reg_id;
            ack_reg    <= head_rec.ack;
            data_reg   <= head_rec.data;
            ones_reg   <= head_rec.ones;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            sel_copy_reg <= 32'd0;
        end
        else
        begin
            if (pop)
                valid_reg <= 1'b1;
            else if (result.ready)
                valid_reg <= 1'b0;
            if (pop && head_rec.kind == swd_pkg::KIND_OK
                    && reg_id == swd_pkg::REG_DP_SELECT)
                sel_copy_reg <= head_rec.data;
        end
    end

    assign result.valid          = valid_reg;
    assign result.record_kind    = kind_reg;
    assign result.request_value  = req_reg;
    assign result.access_port    = req_reg[1];
    assign result.is_read        = req_reg[2];
    assign result.reg_address    = {req_reg[4:3], 2'b00};
    assign result.register_id    = reg_id_reg;
    assign result.ack_code       = ack_reg;
    assign result.data_word      = data_reg;
    assign result.reset_ones     = ones_reg;

endmodule

`default_nettype wire

[src/swd_transaction_decoder.sv]
// Takes one SWDIO bit per cycle; a finished record is written into the record queue and
// then into the output register before it appears on the result channel.
// Throughput: one bit per cycle; input stalls only while the two-entry record queue
// between the bit decoder and the register decoder is full.
// Reset (rst_n low, asynchronous): decoder hunts with empty window, SELECT copy zero,
// line-reset threshold 50, queue and output empty.
`default_nettype none

module swd_transaction_decoder (
    input  wire logic clk,
    input  wire logic rst_n,
    swd_bit_if.sink   sample,
    swd_cfg_if.sink   cfg,
    swd_rec_if.source result
);

    swd_pkg::rec_t push_rec;
    swd_pkg::rec_t head_rec;
    logic          push_valid;
    logic          queue_full;
    logic          head_valid;
    logic          pop;

    swd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push_rec   (push_rec),
        .push_valid (push_valid)
    );

    swd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_rec   (push_rec),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    swd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .result     (result)
    );

endmodule

`default_nettype wire
